@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AST_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AST_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/pidl_pkg.sv @@
// Package with the codes, widths and command types of the positional list.
`timescale 1ns / 1ps

package pidl_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam int MODE_W      = 2;
   localparam int POS_W       = 7;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 8;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic eval;
      logic step_rd;
      logic step_wr;
      logic put;
      logic dec;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic              ok;
      logic              done;
      logic [MODE_W-1:0] mode;
   } dp_sts_type;

endpackage

@@ rtl/pidl_ctrl.sv @@
// Controller state machine that sequences one list request at a time.
`timescale 1ns / 1ps

module pidl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output pidl_pkg::dp_cmd_type cmd,
   input  pidl_pkg::dp_sts_type sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_STEP = 3'd2;
   localparam logic [2:0] S_SHWR = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;
   localparam logic [2:0] S_DROP = 3'd5;
   localparam logic [2:0] S_RESP = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            // A read issues its memory access here and answers next cycle.
            if (!sts.ok || sts.mode == pidl_pkg::MODE_READ) begin
               state_in = S_RESP;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (sts.done) begin
               state_in = (sts.mode == pidl_pkg::MODE_REMOVE) ? S_DROP : S_PUT;
            end else begin
               cmd.step_rd = 1'b1;
               state_in    = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd.step_wr = 1'b1;
            state_in    = S_STEP;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_RESP;
         end
         S_DROP: begin
            cmd.dec  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

endmodule

@@ rtl/pidl_dpath.sv @@
// Datapath: entry memory, count, shift index and result registers.
`timescale 1ns / 1ps

module pidl_dpath #(
   parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic        [pidl_pkg::MODE_W-1:0]       req_mode,
   input  logic        [pidl_pkg::POS_W-1:0]        req_position,
   input  logic signed [pidl_pkg::DATA_W-1:0]       req_value,
   input  pidl_pkg::dp_cmd_type                     cmd,
   output pidl_pkg::dp_sts_type                     sts,
   output logic        [pidl_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [pidl_pkg::DATA_W-1:0]       rsp_read_value,
   output logic        [pidl_pkg::COUNT_OUT_W-1:0]  rsp_count,
   output logic                                     rsp_is_empty
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int TW = (CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W;

   logic [pidl_pkg::DATA_W-1:0] mem [DEPTH];

   logic [CW-1:0]                   count_ff;
   logic [pidl_pkg::MODE_W-1:0]     mode_ff;
   logic [TW-1:0]                   tgt_ff;
   logic [pidl_pkg::DATA_W-1:0]     value_ff;
   logic [pidl_pkg::STATUS_W-1:0]   status_ff;
   logic [IW-1:0]                   idx_ff;
   logic [pidl_pkg::DATA_W-1:0]     rdata_ff;

   logic [pidl_pkg::STATUS_W-1:0]   status_in;
   logic [IW-1:0]                   src;
   logic [IW-1:0]                   raddr;
   logic [pidl_pkg::DATA_W-1:0]     wdata;
   logic                            we;
   logic                            re;
   logic                            full;
   logic [TW-1:0]                   count_ext;

   assign count_ext = TW'(count_ff);
   assign full      = (count_ff == CW'(DEPTH));

   // The target is the list position; for append it is the current end.
   always_comb begin
      unique case (mode_ff)
         pidl_pkg::MODE_INSERT: begin
            if (full) begin
               status_in = pidl_pkg::ST_FULL;
            end else if (tgt_ff > count_ext) begin
               status_in = pidl_pkg::ST_BADPOS;
            end else begin
               status_in = pidl_pkg::ST_DONE;
            end
         end
         pidl_pkg::MODE_APPEND: begin
            status_in = full ? pidl_pkg::ST_FULL : pidl_pkg::ST_DONE;
         end
         default: begin
            status_in = (tgt_ff >= count_ext) ? pidl_pkg::ST_BADPOS : pidl_pkg::ST_DONE;
         end
      endcase
   end

   // Insert walks down from the end, remove walks up from the target.
   assign src = (mode_ff == pidl_pkg::MODE_REMOVE) ? idx_ff + IW'(1) : idx_ff - IW'(1);

   assign sts.ok   = (status_in == pidl_pkg::ST_DONE);
   assign sts.mode = mode_ff;
   assign sts.done = (mode_ff == pidl_pkg::MODE_REMOVE) ?
                     ((CW'(idx_ff) + CW'(1)) >= count_ff) : (idx_ff == tgt_ff[IW-1:0]);

   assign re    = cmd.step_rd | (cmd.eval & sts.ok & (mode_ff == pidl_pkg::MODE_READ));
   assign raddr = cmd.eval ? tgt_ff[IW-1:0] : src;
   assign we    = cmd.step_wr | cmd.put;
   assign wdata = cmd.put ? value_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[idx_ff] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.put) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         tgt_ff   <= (req_mode == pidl_pkg::MODE_APPEND) ? count_ext : TW'(req_position);
      end
      if (cmd.eval) begin
         status_ff <= status_in;
         idx_ff    <= (mode_ff == pidl_pkg::MODE_REMOVE) ? tgt_ff[IW-1:0] : count_ff[IW-1:0];
      end else if (cmd.step_wr) begin
         idx_ff <= src;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = (mode_ff == pidl_pkg::MODE_READ && status_ff == pidl_pkg::ST_DONE) ?
                           $signed(rdata_ff) : '0;
   assign rsp_count      = pidl_pkg::COUNT_OUT_W'(count_ff);
   assign rsp_is_empty   = (count_ff == '0);

endmodule

@@ rtl/positional_insert_delete_list.sv @@
// Top level of the bounded positional list: controller plus datapath.
//
// A request beat is taken at a rising edge with start high and busy low; it
// carries req_mode (insert, append, remove, read), req_position and req_value.
// Exactly one result beat follows, shown for one cycle with rsp_strobe high:
// rsp_status, rsp_read_value (zero unless a successful read), rsp_count and
// rsp_is_empty, all as they stand after the request.
// Entries live in a single-port-write, single-port-read memory, so shifting
// moves one entry at a time through a read step followed by a write step.
// A rejected request or a read goes from evaluation straight to the result
// beat. Append, insert and remove run the shift steps, then write the new
// entry or lower the count before the result beat; insert at p shifts
// count - p entries, remove at p shifts count - p - 1, append shifts none.
// busy falls the cycle after the strobe, so a new request is taken only once
// the result beat of the last one is out.
// The result is never held: the receiver must take it in its strobe cycle.
// Reset empties the list and returns the controller to idle; memory contents
// are left as they are and are only read at positions below the count.
`timescale 1ns / 1ps

module positional_insert_delete_list #(
   parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic        [pidl_pkg::MODE_W-1:0]       req_mode,
   input  logic        [pidl_pkg::POS_W-1:0]        req_position,
   input  logic signed [pidl_pkg::DATA_W-1:0]       req_value,
   output logic                                     rsp_strobe,
   output logic        [pidl_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [pidl_pkg::DATA_W-1:0]       rsp_read_value,
   output logic        [pidl_pkg::COUNT_OUT_W-1:0]  rsp_count,
   output logic                                     rsp_is_empty
);

   pidl_pkg::dp_cmd_type cmd;
   pidl_pkg::dp_sts_type sts;

   pidl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   pidl_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty)
   );

endmodule

@@ rtl/pidl_checker.sv @@
// Port-level checker for the positional list, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidl_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     start,
   input logic                                     busy,
   input logic                                     rsp_strobe,
   input logic        [pidl_pkg::STATUS_W-1:0]     rsp_status,
   input logic signed [pidl_pkg::DATA_W-1:0]       rsp_read_value
);

   // An accepted request keeps the block busy until its result beat.
   `AST_NXT(a_accept_busy, start && !busy, busy)
   // A result beat only appears while a request is in flight.
   `AST_IMP(a_strobe_busy, rsp_strobe, busy)
   // After the result beat the block is free for the next request.
   `AST_NXT(a_strobe_free, rsp_strobe, !busy && !rsp_strobe)
   // A failed request never returns data.
   `AST_IMP(a_fail_zero, rsp_strobe && rsp_status != pidl_pkg::ST_DONE, rsp_read_value == '0)

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value)
);
